// ===== hw/rtl/dual_stage_thermostat_macros.svh =====
// assertion macros for the dual stage thermostat
`ifndef DUAL_STAGE_THERMOSTAT_MACROS_SVH
`define DUAL_STAGE_THERMOSTAT_MACROS_SVH

// same-cycle implication, checked out of reset
`define DST_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define DST_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== hw/rtl/dst_pkg.sv =====
// shared types and constants for the dual stage thermostat
`timescale 1ns / 1ps

package dst_pkg;

   localparam int DIFF_WIDTH      = 15;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SETPOINT          = 3'd0,
      CSR_HEAT_DIFFERENTIAL = 3'd1,
      CSR_COOL_DIFFERENTIAL = 3'd2,
      CSR_COOL_MIN_ON_MS    = 3'd3,
      CSR_COOL_MIN_OFF_MS   = 3'd4,
      CSR_CHANGEOVER_MS     = 3'd5,
      CSR_CONTROL_ENABLE    = 3'd6
   } dst_csr_index_type;

   typedef struct packed {
      logic heat;
      logic cool;
   } dst_drive_type;

endpackage

// ===== hw/rtl/dst_csr_regs.sv =====
// configuration register file for the dual stage thermostat
`timescale 1ns / 1ps

module dst_csr_regs #(
   parameter int TEMP_WIDTH = 16,
   parameter int TIME_WIDTH = 32,
   parameter int CSR_WIDTH  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [dst_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_WIDTH-1:0]                 csr_wdata,
   output logic signed [TEMP_WIDTH-1:0]         setpoint,
   output logic [dst_pkg::DIFF_WIDTH-1:0]       heat_differential,
   output logic [dst_pkg::DIFF_WIDTH-1:0]       cool_differential,
   output logic [TIME_WIDTH-1:0]                cool_min_on_ms,
   output logic [TIME_WIDTH-1:0]                cool_min_off_ms,
   output logic [TIME_WIDTH-1:0]                changeover_ms,
   output logic                                 control_enable
);
   import dst_pkg::*;

   logic signed [TEMP_WIDTH-1:0] setpoint_ff, setpoint_in;
   logic [DIFF_WIDTH-1:0]        heat_diff_ff, heat_diff_in;
   logic [DIFF_WIDTH-1:0]        cool_diff_ff, cool_diff_in;
   logic [TIME_WIDTH-1:0]        min_on_ff, min_on_in;
   logic [TIME_WIDTH-1:0]        min_off_ff, min_off_in;
   logic [TIME_WIDTH-1:0]        changeover_ff, changeover_in;
   logic                         enable_ff, enable_in;

   always_comb begin
      setpoint_in   = setpoint_ff;
      heat_diff_in  = heat_diff_ff;
      cool_diff_in  = cool_diff_ff;
      min_on_in     = min_on_ff;
      min_off_in    = min_off_ff;
      changeover_in = changeover_ff;
      enable_in     = enable_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SETPOINT:          setpoint_in   = csr_wdata[TEMP_WIDTH-1:0];
            CSR_HEAT_DIFFERENTIAL: heat_diff_in  = csr_wdata[DIFF_WIDTH-1:0];
            CSR_COOL_DIFFERENTIAL: cool_diff_in  = csr_wdata[DIFF_WIDTH-1:0];
            CSR_COOL_MIN_ON_MS:    min_on_in     = csr_wdata[TIME_WIDTH-1:0];
            CSR_COOL_MIN_OFF_MS:   min_off_in    = csr_wdata[TIME_WIDTH-1:0];
            CSR_CHANGEOVER_MS:     changeover_in = csr_wdata[TIME_WIDTH-1:0];
            CSR_CONTROL_ENABLE:    enable_in     = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff   <= '0;
         heat_diff_ff  <= '0;
         cool_diff_ff  <= '0;
         min_on_ff     <= '0;
         min_off_ff    <= '0;
         changeover_ff <= '0;
         enable_ff     <= 1'b0;
      end else begin
         setpoint_ff   <= setpoint_in;
         heat_diff_ff  <= heat_diff_in;
         cool_diff_ff  <= cool_diff_in;
         min_on_ff     <= min_on_in;
         min_off_ff    <= min_off_in;
         changeover_ff <= changeover_in;
         enable_ff     <= enable_in;
      end
   end

   assign setpoint          = setpoint_ff;
   assign heat_differential = heat_diff_ff;
   assign cool_differential = cool_diff_ff;
   assign cool_min_on_ms    = min_on_ff;
   assign cool_min_off_ms   = min_off_ff;
   assign changeover_ms     = changeover_ff;
   assign control_enable    = enable_ff;

endmodule

// ===== hw/rtl/dst_ctrl.sv =====
// stage decision logic and stage timing state for the dual stage thermostat
`timescale 1ns / 1ps

module dst_ctrl #(
   parameter int TEMP_WIDTH = 16,
   parameter int TIME_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic signed [TEMP_WIDTH-1:0]    sample_value,
   input  logic                            sample_valid,
   input  logic [TIME_WIDTH-1:0]           now_ms,
   input  logic signed [TEMP_WIDTH-1:0]    setpoint,
   input  logic [dst_pkg::DIFF_WIDTH-1:0]  heat_differential,
   input  logic [dst_pkg::DIFF_WIDTH-1:0]  cool_differential,
   input  logic [TIME_WIDTH-1:0]           cool_min_on_ms,
   input  logic [TIME_WIDTH-1:0]           cool_min_off_ms,
   input  logic [TIME_WIDTH-1:0]           changeover_ms,
   input  logic                            control_enable,
   output dst_pkg::dst_drive_type          drive_next
);
   import dst_pkg::*;

   localparam int CMP_WIDTH = ((TEMP_WIDTH > DIFF_WIDTH) ? TEMP_WIDTH : DIFF_WIDTH) + 2;

   logic                  heat_active_ff, heat_active_in;
   logic                  cool_active_ff, cool_active_in;
   logic [TIME_WIDTH-1:0] heat_off_time_ff, heat_off_time_in;
   logic [TIME_WIDTH-1:0] cool_off_time_ff, cool_off_time_in;
   logic [TIME_WIDTH-1:0] cool_on_time_ff, cool_on_time_in;
   logic                  heat_off_known_ff, heat_off_known_in;
   logic                  cool_off_known_ff, cool_off_known_in;

   logic signed [CMP_WIDTH-1:0] temp_ext, sp_ext, heat_on_level, cool_on_level;
   logic [TIME_WIDTH-1:0]       since_heat_off, since_cool_off, since_cool_on;
   logic run, want_heat, want_cool, cool_min_off_block, cool_hold;
   logic heat_b, cool_b, heat_c, cool_c, changeover_on;

   assign temp_ext = {{(CMP_WIDTH-TEMP_WIDTH){sample_value[TEMP_WIDTH-1]}}, sample_value};
   assign sp_ext   = {{(CMP_WIDTH-TEMP_WIDTH){setpoint[TEMP_WIDTH-1]}}, setpoint};
   assign heat_on_level = sp_ext - $signed({{(CMP_WIDTH-DIFF_WIDTH){1'b0}}, heat_differential});
   assign cool_on_level = sp_ext + $signed({{(CMP_WIDTH-DIFF_WIDTH){1'b0}}, cool_differential});

   // wrap-around elapsed times
   assign since_heat_off = now_ms - heat_off_time_ff;
   assign since_cool_off = now_ms - cool_off_time_ff;
   assign since_cool_on  = now_ms - cool_on_time_ff;

   assign run           = control_enable && sample_valid;
   assign changeover_on = (changeover_ms != '0);

   always_comb begin
      want_heat = heat_active_ff ? (temp_ext < sp_ext) : (temp_ext < heat_on_level);
      want_cool = cool_active_ff ? (temp_ext > sp_ext) : (temp_ext > cool_on_level);

      cool_min_off_block = !cool_active_ff && (cool_min_off_ms != '0) && cool_off_known_ff &&
                           (since_cool_off < cool_min_off_ms);
      cool_b = want_cool && !cool_min_off_block;

      // compressor held on by its minimum-on window
      cool_hold = !cool_b && cool_active_ff && (cool_min_on_ms != '0) &&
                  (since_cool_on < cool_min_on_ms);
      heat_b = want_heat && !cool_hold;
      cool_b = cool_b || cool_hold;

      heat_c = heat_b && !(changeover_on && !heat_active_ff &&
               (cool_active_ff || (cool_off_known_ff && (since_cool_off < changeover_ms))));
      cool_c = cool_b && !(changeover_on && !cool_active_ff &&
               (heat_active_ff || (heat_off_known_ff && (since_heat_off < changeover_ms))));

      drive_next.heat = run && heat_c && !cool_c;
      drive_next.cool = run && cool_c && !heat_c;
   end

   always_comb begin
      heat_active_in    = heat_active_ff;
      cool_active_in    = cool_active_ff;
      heat_off_time_in  = heat_off_time_ff;
      cool_off_time_in  = cool_off_time_ff;
      cool_on_time_in   = cool_on_time_ff;
      heat_off_known_in = heat_off_known_ff;
      cool_off_known_in = cool_off_known_ff;
      if (step) begin
         heat_active_in = drive_next.heat;
         cool_active_in = drive_next.cool;
         if (heat_active_ff && !drive_next.heat) begin
            heat_off_time_in  = now_ms;
            heat_off_known_in = 1'b1;
         end
         if (cool_active_ff && !drive_next.cool) begin
            cool_off_time_in  = now_ms;
            cool_off_known_in = 1'b1;
         end
         if (!cool_active_ff && drive_next.cool) begin
            cool_on_time_in = now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heat_active_ff    <= 1'b0;
         cool_active_ff    <= 1'b0;
         heat_off_time_ff  <= '0;
         cool_off_time_ff  <= '0;
         cool_on_time_ff   <= '0;
         heat_off_known_ff <= 1'b0;
         cool_off_known_ff <= 1'b0;
      end else begin
         heat_active_ff    <= heat_active_in;
         cool_active_ff    <= cool_active_in;
         heat_off_time_ff  <= heat_off_time_in;
         cool_off_time_ff  <= cool_off_time_in;
         cool_on_time_ff   <= cool_on_time_in;
         heat_off_known_ff <= heat_off_known_in;
         cool_off_known_ff <= cool_off_known_in;
      end
   end

endmodule

// ===== hw/rtl/dual_stage_thermostat.sv =====
// top level of the dual stage thermostat
// req channel: one beat per control tick carrying sample_value, sample_valid
//   and now_ms; rsp channel: one beat per tick carrying heat_drive and
//   cool_drive, in tick order
// csr port: write enable, register index and data, to be written by the user only
//   while idle (the block does not enforce this); unknown indexes are ignored
// path: a req beat lands in the input register, the decision is taken from that
//   register and the rsp beat is registered in the result register
// throughput: one tick per cycle while rsp_ready is high, set by the combinational
//   decision between the input register and the result register
// stalls: while rsp_ready is low the result register holds its beat; one more
//   req beat may wait in the input register, then req_ready drops
// reset: synchronous, clears the valid flags of both pipeline stages, all stage
//   state and all configuration registers (controller disabled)
`timescale 1ns / 1ps

module dual_stage_thermostat #(
   parameter int TEMP_WIDTH = 16,
   parameter int TIME_WIDTH = 32
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_valid,
   output logic                                           req_ready,
   input  logic signed [TEMP_WIDTH-1:0]                   req_sample_value,
   input  logic                                           req_sample_valid,
   input  logic [TIME_WIDTH-1:0]                          req_now_ms,
   output logic                                           rsp_valid,
   input  logic                                           rsp_ready,
   output logic                                           rsp_heat_drive,
   output logic                                           rsp_cool_drive,
   input  logic                                           csr_we,
   input  logic [dst_pkg::CSR_INDEX_WIDTH-1:0]            csr_index,
   input  logic [((TEMP_WIDTH > TIME_WIDTH) ? TEMP_WIDTH : TIME_WIDTH)-1:0] csr_wdata
);
   import dst_pkg::*;

   `include "dual_stage_thermostat_macros.svh"

   localparam int CSR_WIDTH = (TEMP_WIDTH > TIME_WIDTH) ? TEMP_WIDTH : TIME_WIDTH;

   logic signed [TEMP_WIDTH-1:0] setpoint;
   logic [DIFF_WIDTH-1:0]        heat_differential, cool_differential;
   logic [TIME_WIDTH-1:0]        cool_min_on_ms, cool_min_off_ms, changeover_ms;
   logic                         control_enable;

   logic                         in_valid_ff, in_valid_in;
   logic signed [TEMP_WIDTH-1:0] in_value_ff, in_value_in;
   logic                         in_flag_ff, in_flag_in;
   logic [TIME_WIDTH-1:0]        in_now_ff, in_now_in;
   logic                         out_valid_ff, out_valid_in;
   dst_drive_type                out_drive_ff, out_drive_in;
   dst_drive_type                drive_next;
   logic                         advance, req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   dst_csr_regs #(
      .TEMP_WIDTH (TEMP_WIDTH),
      .TIME_WIDTH (TIME_WIDTH),
      .CSR_WIDTH  (CSR_WIDTH)
   ) u_csr (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .setpoint          (setpoint),
      .heat_differential (heat_differential),
      .cool_differential (cool_differential),
      .cool_min_on_ms    (cool_min_on_ms),
      .cool_min_off_ms   (cool_min_off_ms),
      .changeover_ms     (changeover_ms),
      .control_enable    (control_enable)
   );

   dst_ctrl #(
      .TEMP_WIDTH (TEMP_WIDTH),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .step              (advance),
      .sample_value      (in_value_ff),
      .sample_valid      (in_flag_ff),
      .now_ms            (in_now_ff),
      .setpoint          (setpoint),
      .heat_differential (heat_differential),
      .cool_differential (cool_differential),
      .cool_min_on_ms    (cool_min_on_ms),
      .cool_min_off_ms   (cool_min_off_ms),
      .changeover_ms     (changeover_ms),
      .control_enable    (control_enable),
      .drive_next        (drive_next)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_value_in = in_value_ff;
      in_flag_in  = in_flag_ff;
      in_now_in   = in_now_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_value_in = req_sample_value;
         in_flag_in  = req_sample_valid;
         in_now_in   = req_now_ms;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_drive_in = out_drive_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_drive_in = drive_next;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_value_ff  <= in_value_in;
      in_flag_ff   <= in_flag_in;
      in_now_ff    <= in_now_in;
      out_drive_ff <= out_drive_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_heat_drive = out_drive_ff.heat;
   assign rsp_cool_drive = out_drive_ff.cool;

   `DST_ASSERT_SAME(a_never_both, clock, reset, rsp_valid, !(rsp_heat_drive && rsp_cool_drive), "heat and cool driven together")
   `DST_ASSERT_NEXT(a_disabled_off, clock, reset, advance && !control_enable, !rsp_heat_drive && !rsp_cool_drive, "drive on while disabled")
   `DST_ASSERT_SAME(a_ready_when_drained, clock, reset, rsp_ready, req_ready, "req stalled although rsp side drains")
   `DST_ASSERT_NEXT(a_result_follows, clock, reset, in_valid_ff && (!rsp_valid || rsp_ready), rsp_valid, "tick lost between stages")

endmodule

// ===== tb/dual_stage_thermostat_checker.sv =====
// checker for the dual stage thermostat: predicts the drive beat of every tick and compares it
`timescale 1ns / 1ps

module dual_stage_thermostat_checker #(
   parameter int TEMP_WIDTH = 16,
   parameter int TIME_WIDTH = 32,
   parameter int CSR_WIDTH  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [TEMP_WIDTH-1:0]        req_sample_value,
   input  logic                                req_sample_valid,
   input  logic [TIME_WIDTH-1:0]               req_now_ms,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_heat_drive,
   input  logic                                rsp_cool_drive,
   input  logic                                csr_we,
   input  logic [dst_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]                csr_wdata,
   output int                                  fail_count,
   output int                                  pending_ticks,
   output int                                  ticks_checked,
   output int                                  heat_ticks,
   output int                                  cool_ticks
);

   import dst_pkg::*;

   localparam int MAX_REPORTS = 10;

   // register copies
   logic signed [TEMP_WIDTH-1:0] cfg_setpoint;
   logic [DIFF_WIDTH-1:0]        cfg_heat_diff;
   logic [DIFF_WIDTH-1:0]        cfg_cool_diff;
   logic [TIME_WIDTH-1:0]        cfg_min_on;
   logic [TIME_WIDTH-1:0]        cfg_min_off;
   logic [TIME_WIDTH-1:0]        cfg_changeover;
   logic                         cfg_enable;

   // stage state
   logic                  heat_on;
   logic                  cool_on;
   logic [TIME_WIDTH-1:0] heat_off_at;
   logic [TIME_WIDTH-1:0] cool_off_at;
   logic [TIME_WIDTH-1:0] cool_on_at;
   logic                  heat_off_seen;
   logic                  cool_off_seen;

   dst_drive_type drive_queue[$];

   function automatic logic [TIME_WIDTH-1:0] elapsed_ms(input logic [TIME_WIDTH-1:0] now,
                                                        input logic [TIME_WIDTH-1:0] since);
      return now - since;
   endfunction

   task automatic clear_controller();
      cfg_setpoint   = '0;
      cfg_heat_diff  = '0;
      cfg_cool_diff  = '0;
      cfg_min_on     = '0;
      cfg_min_off    = '0;
      cfg_changeover = '0;
      cfg_enable     = 1'b0;
      heat_on        = 1'b0;
      cool_on        = 1'b0;
      heat_off_at    = '0;
      cool_off_at    = '0;
      cool_on_at     = '0;
      heat_off_seen  = 1'b0;
      cool_off_seen  = 1'b0;
      drive_queue.delete();
   endtask

   task automatic advance_controller(input logic signed [TEMP_WIDTH-1:0] sample,
                                     input logic sample_ok,
                                     input logic [TIME_WIDTH-1:0] now,
                                     output dst_drive_type drive);
      longint temp_l;
      longint sp_l;
      logic   want_heat;
      logic   want_cool;
      if (!cfg_enable || !sample_ok) begin
         if (heat_on) begin
            heat_on       = 1'b0;
            heat_off_at   = now;
            heat_off_seen = 1'b1;
         end
         if (cool_on) begin
            cool_on       = 1'b0;
            cool_off_at   = now;
            cool_off_seen = 1'b1;
         end
      end else begin
         temp_l    = longint'(sample);
         sp_l      = longint'(cfg_setpoint);
         want_heat = heat_on ? (temp_l < sp_l) : (temp_l < sp_l - longint'(cfg_heat_diff));
         want_cool = cool_on ? (temp_l > sp_l) : (temp_l > sp_l + longint'(cfg_cool_diff));

         // minimum off window
         if (want_cool && !cool_on && cfg_min_off != 0 && cool_off_seen &&
             elapsed_ms(now, cool_off_at) < cfg_min_off)
            want_cool = 1'b0;
         // minimum on window holds cooling and cancels heat
         if (!want_cool && cool_on && cfg_min_on != 0 &&
             elapsed_ms(now, cool_on_at) < cfg_min_on) begin
            want_cool = 1'b1;
            want_heat = 1'b0;
         end

         if (cfg_changeover != 0) begin
            if (want_heat && !heat_on &&
                (cool_on || (cool_off_seen && elapsed_ms(now, cool_off_at) < cfg_changeover)))
               want_heat = 1'b0;
            if (want_cool && !cool_on &&
                (heat_on || (heat_off_seen && elapsed_ms(now, heat_off_at) < cfg_changeover)))
               want_cool = 1'b0;
         end

         if (want_heat && want_cool) begin
            want_heat = 1'b0;
            want_cool = 1'b0;
         end

         if (want_heat != heat_on) begin
            heat_on = want_heat;
            if (!want_heat) begin
               heat_off_at   = now;
               heat_off_seen = 1'b1;
            end
         end
         if (want_cool != cool_on) begin
            cool_on = want_cool;
            if (want_cool) begin
               cool_on_at = now;
            end else begin
               cool_off_at   = now;
               cool_off_seen = 1'b1;
            end
         end
      end
      drive.heat = heat_on;
      drive.cool = cool_on;
   endtask

   initial begin
      fail_count    = 0;
      pending_ticks = 0;
      ticks_checked = 0;
      heat_ticks    = 0;
      cool_ticks    = 0;
      clear_controller();
   end

   always @(posedge clock) begin : watch
      dst_drive_type predicted;
      dst_drive_type expected;
      if (reset) begin
         clear_controller();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SETPOINT:          cfg_setpoint   = csr_wdata[TEMP_WIDTH-1:0];
               CSR_HEAT_DIFFERENTIAL: cfg_heat_diff  = csr_wdata[DIFF_WIDTH-1:0];
               CSR_COOL_DIFFERENTIAL: cfg_cool_diff  = csr_wdata[DIFF_WIDTH-1:0];
               CSR_COOL_MIN_ON_MS:    cfg_min_on     = csr_wdata[TIME_WIDTH-1:0];
               CSR_COOL_MIN_OFF_MS:   cfg_min_off    = csr_wdata[TIME_WIDTH-1:0];
               CSR_CHANGEOVER_MS:     cfg_changeover = csr_wdata[TIME_WIDTH-1:0];
               CSR_CONTROL_ENABLE:    cfg_enable     = csr_wdata[0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            advance_controller(req_sample_value, req_sample_valid, req_now_ms, predicted);
            drive_queue.push_back(predicted);
         end

         if (rsp_valid && rsp_ready) begin
            if (drive_queue.size() == 0) begin
               if (fail_count < MAX_REPORTS)
                  $display("%0t: drive beat with no tick outstanding: heat %0b cool %0b",
                           $realtime, rsp_heat_drive, rsp_cool_drive);
               fail_count++;
            end else begin
               expected = drive_queue.pop_front();
               ticks_checked++;
               if (rsp_heat_drive) heat_ticks++;
               if (rsp_cool_drive) cool_ticks++;
               if (rsp_heat_drive !== expected.heat || rsp_cool_drive !== expected.cool) begin
                  if (fail_count < MAX_REPORTS)
                     $display("%0t: tick %0d drive mismatch: heat exp %0b got %0b, cool exp %0b got %0b",
                              $realtime, ticks_checked, expected.heat, rsp_heat_drive,
                              expected.cool, rsp_cool_drive);
                  fail_count++;
               end
            end
         end
      end
      pending_ticks = drive_queue.size();
   end

endmodule

// ===== tb/testbench.sv =====
// top of the dual stage thermostat testbench: clock, reset, tick stimulus and verdict
`timescale 1ns / 1ps

module testbench;

   import dst_pkg::*;

   localparam int TEMP_WIDTH   = 16;
   localparam int TIME_WIDTH   = 32;
   localparam int CSR_WIDTH    = 32;
   localparam int PHASE_COUNT  = 20;
   localparam int PHASE_TICKS  = 100;
   localparam int HOLD_PHASE   = 4;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 3'd7;

   localparam logic signed [TEMP_WIDTH-1:0] TEMP_MIN = 16'sh8000;
   localparam logic signed [TEMP_WIDTH-1:0] TEMP_MAX = 16'sh7FFF;

   // kinds of register setting
   localparam int SETTING_RANDOM  = 0;
   localparam int SETTING_ALL_LOW = 1;
   localparam int SETTING_ALL_MAX = 2;

   logic                         clock            = 1'b0;
   logic                         reset            = 1'b1;
   logic                         req_valid        = 1'b0;
   logic                         req_ready;
   logic signed [TEMP_WIDTH-1:0] req_sample_value = '0;
   logic                         req_sample_valid = 1'b0;
   logic [TIME_WIDTH-1:0]        req_now_ms       = '0;
   logic                         rsp_valid;
   logic                         rsp_ready        = 1'b0;
   logic                         rsp_heat_drive;
   logic                         rsp_cool_drive;
   logic                         csr_we           = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index        = '0;
   logic [CSR_WIDTH-1:0]         csr_wdata        = '0;

   int fail_count;
   int pending_ticks;
   int ticks_checked;
   int heat_ticks;
   int cool_ticks;

   int    cycle_count    = 0;
   int    settings_count = 0;
   logic  sender_gaps    = 1'b1;
   logic  receiver_gaps  = 1'b1;
   logic  hold_request   = 1'b0;
   int    cur_setpoint   = 0;
   int    cur_band       = 64;
   int    temp_track     = 0;
   int    step_max       = 10;
   logic [TIME_WIDTH-1:0] now_track = '0;

   dual_stage_thermostat #(
      .TEMP_WIDTH(TEMP_WIDTH),
      .TIME_WIDTH(TIME_WIDTH)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .req_sample_valid (req_sample_valid),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_heat_drive   (rsp_heat_drive),
      .rsp_cool_drive   (rsp_cool_drive),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   dual_stage_thermostat_checker #(
      .TEMP_WIDTH(TEMP_WIDTH),
      .TIME_WIDTH(TIME_WIDTH),
      .CSR_WIDTH (CSR_WIDTH)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .req_sample_valid (req_sample_valid),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_heat_drive   (rsp_heat_drive),
      .rsp_cool_drive   (rsp_cool_drive),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_ticks    (pending_ticks),
      .ticks_checked    (ticks_checked),
      .heat_ticks       (heat_ticks),
      .cool_ticks       (cool_ticks)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d ticks outstanding", cycle_count, pending_ticks);
         $display("FAIL dual_stage_thermostat");
         $finish;
      end
   end

   // result side: random stalls per beat, one long hold-off on request
   initial begin : receiver
      int wait_cycles;
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         wait_cycles = receiver_gaps ? $urandom_range(0, 7) : 0;
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_tick(input logic signed [TEMP_WIDTH-1:0] value, input logic ok,
                            input logic [TIME_WIDTH-1:0] stamp);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_value <= value;
      req_sample_valid <= ok;
      req_now_ms       <= stamp;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_ticks != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   function automatic logic [DIFF_WIDTH-1:0] pick_diff();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return DIFF_WIDTH'($urandom_range(0, 400));
      endcase
   endfunction

   function automatic logic [TIME_WIDTH-1:0] pick_window();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return $urandom_range(1, 300);
      endcase
   endfunction

   task automatic configure(input int kind);
      logic [31:0]                  junk;
      logic [31:0]                  draw;
      logic signed [TEMP_WIDTH-1:0] sp;
      logic [DIFF_WIDTH-1:0]        heat_d;
      logic [DIFF_WIDTH-1:0]        cool_d;
      logic [TIME_WIDTH-1:0]        on_ms;
      logic [TIME_WIDTH-1:0]        off_ms;
      logic [TIME_WIDTH-1:0]        change_ms;
      logic                         enable;
      junk = $urandom;
      case (kind)
         SETTING_ALL_LOW: begin
            sp = TEMP_MIN;
            heat_d = '0;
            cool_d = '0;
            on_ms = '0;
            off_ms = '0;
            change_ms = '0;
            enable = 1'b1;
         end
         SETTING_ALL_MAX: begin
            sp = TEMP_MAX;
            heat_d = '1;
            cool_d = '1;
            on_ms = '1;
            off_ms = '1;
            change_ms = '1;
            enable = 1'b1;
         end
         default: begin
            draw = $urandom;
            case ($urandom_range(0, 7))
               0:       sp = TEMP_MIN;
               1:       sp = TEMP_MAX;
               default: sp = draw[TEMP_WIDTH-1:0];
            endcase
            heat_d = pick_diff();
            cool_d = pick_diff();
            on_ms = pick_window();
            off_ms = pick_window();
            change_ms = pick_window();
            enable = ($urandom_range(0, 7) != 0);
         end
      endcase
      write_reg(CSR_SETPOINT, {junk[31:TEMP_WIDTH], sp});
      write_reg(CSR_HEAT_DIFFERENTIAL, {junk[31:DIFF_WIDTH], heat_d});
      write_reg(CSR_COOL_DIFFERENTIAL, {~junk[31:DIFF_WIDTH], cool_d});
      write_reg(CSR_COOL_MIN_ON_MS, on_ms);
      write_reg(CSR_COOL_MIN_OFF_MS, off_ms);
      write_reg(CSR_CHANGEOVER_MS, change_ms);
      write_reg(CSR_CONTROL_ENABLE, {junk[31:1], enable});
      write_reg(CSR_UNMAPPED, ~junk);
      csr_we <= 1'b0;
      cur_setpoint = int'(sp);
      cur_band = ((heat_d > cool_d) ? int'(heat_d) : int'(cool_d)) + 32;
      temp_track = cur_setpoint;
      settings_count++;
   endtask

   // one random tick: mostly a drifting temperature near the setpoint
   task automatic random_tick();
      logic [31:0]                  draw;
      logic signed [TEMP_WIDTH-1:0] value;
      int                           drift;
      int                           pick;
      draw = $urandom;
      now_track = now_track + $urandom_range(0, step_max);
      if ($urandom_range(0, 99) == 0)
         now_track = $urandom;
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
         value = draw[TEMP_WIDTH-1:0];
      end else begin
         drift = cur_band / 8 + 1;
         if (pick == 1)
            temp_track = cur_setpoint + int'($urandom_range(0, 2 * cur_band)) - cur_band;
         else
            temp_track = temp_track + int'($urandom_range(0, 2 * drift)) - drift;
         if (temp_track > cur_setpoint + cur_band) temp_track = cur_setpoint + cur_band;
         if (temp_track < cur_setpoint - cur_band) temp_track = cur_setpoint - cur_band;
         if (temp_track > 32767) temp_track = 32767;
         if (temp_track < -32768) temp_track = -32768;
         value = temp_track[TEMP_WIDTH-1:0];
      end
      send_tick(value, ($urandom_range(0, 19) != 0), now_track);
   endtask

   initial begin : stimulus
      int phase;
      int tick;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // controller still disabled from reset
      send_tick(TEMP_MIN, 1'b1, 32'd0);
      drain();
      write_reg(CSR_HEAT_DIFFERENTIAL, 32'd100);
      write_reg(CSR_COOL_DIFFERENTIAL, 32'd100);
      write_reg(CSR_CONTROL_ENABLE, 32'd1);
      write_reg(CSR_UNMAPPED, 32'hFFFF_FFFF);
      write_reg(CSR_SETPOINT, 32'd0);
      csr_we <= 1'b0;
      settings_count++;

      // hysteresis without timing windows
      send_tick(TEMP_MIN, 1'b1, 32'd10);
      send_tick(-16'sd50, 1'b1, 32'd20);
      send_tick(-16'sd1, 1'b1, 32'd30);
      send_tick(16'sd0, 1'b1, 32'd40);
      send_tick(-16'sd100, 1'b1, 32'd50);
      send_tick(TEMP_MAX, 1'b1, 32'd60);
      send_tick(16'sd1, 1'b1, 32'd70);
      send_tick(TEMP_MAX, 1'b0, 32'd80);
      send_tick(TEMP_MAX, 1'b1, 32'd90);
      send_tick(TEMP_MIN, 1'b1, 32'd100);

      // disable while heating
      drain();
      write_reg(CSR_CONTROL_ENABLE, 32'hFFFF_FFFE);
      csr_we <= 1'b0;
      send_tick(TEMP_MIN, 1'b1, 32'd110);

      // minimum on/off and changeover windows
      drain();
      write_reg(CSR_CONTROL_ENABLE, 32'd1);
      write_reg(CSR_COOL_MIN_ON_MS, 32'd50);
      write_reg(CSR_COOL_MIN_OFF_MS, 32'd30);
      write_reg(CSR_CHANGEOVER_MS, 32'd100);
      csr_we <= 1'b0;
      settings_count++;
      send_tick(TEMP_MAX, 1'b1, 32'd200);
      send_tick(TEMP_MAX, 1'b1, 32'd215);
      send_tick(TEMP_MIN, 1'b1, 32'd230);
      send_tick(TEMP_MIN, 1'b1, 32'd270);
      send_tick(TEMP_MIN, 1'b1, 32'd300);
      send_tick(TEMP_MIN, 1'b1, 32'd375);
      send_tick(TEMP_MAX, 1'b1, 32'd380);
      send_tick(TEMP_MAX, 1'b1, 32'd400);
      send_tick(TEMP_MAX, 1'b1, 32'd490);

      // timestamp wrap across the minimum off window
      drain();
      write_reg(CSR_CHANGEOVER_MS, 32'd0);
      write_reg(CSR_COOL_MIN_OFF_MS, 32'd100);
      csr_we <= 1'b0;
      settings_count++;
      send_tick(TEMP_MIN, 1'b1, 32'hFFFF_FFF0);
      send_tick(TEMP_MAX, 1'b1, 32'h0000_0010);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         drain();
         if (phase == PHASE_COUNT - 2)
            configure(SETTING_ALL_MAX);
         else if (phase == PHASE_COUNT - 1)
            configure(SETTING_ALL_LOW);
         else
            configure(SETTING_RANDOM);
         case ($urandom_range(0, 2))
            0:       step_max = 4;
            1:       step_max = 40;
            default: step_max = 400;
         endcase
         now_track = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom;
         sender_gaps = ($urandom_range(0, 3) != 0);
         receiver_gaps = ($urandom_range(0, 3) != 0);
         if (phase == HOLD_PHASE) begin
            sender_gaps = 1'b0;
            hold_request = 1'b1;
         end
         for (tick = 0; tick < PHASE_TICKS; tick++) begin
            random_tick();
            if ($urandom_range(0, 149) == 0)
               drain();
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("checked %0d drive beats over %0d register settings", ticks_checked,
               settings_count);
      $display("heat stage on in %0d beats, cool stage on in %0d beats", heat_ticks,
               cool_ticks);
      if (fail_count == 0 && pending_ticks == 0) begin
         $display("PASS dual_stage_thermostat");
      end else begin
         $display("%0d failures, %0d ticks outstanding", fail_count, pending_ticks);
         $display("FAIL dual_stage_thermostat");
      end
      $finish;
   end

endmodule

// ===== dual_stage_thermostat.f =====
+incdir+hw/rtl
hw/rtl/dst_pkg.sv
hw/rtl/dst_csr_regs.sv
hw/rtl/dst_ctrl.sv
hw/rtl/dual_stage_thermostat.sv
tb/dual_stage_thermostat_checker.sv
tb/testbench.sv
